@@ src/display_fill_rect_byte_sequencer_assert.svh @@
// Assertion macros used by the rectangle-fill sequencer engine.
`ifndef DISPLAY_FILL_RECT_BYTE_SEQUENCER_ASSERT_SVH
`define DISPLAY_FILL_RECT_BYTE_SEQUENCER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define DFRS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dfrs_pkg.sv @@
// Shared types and constants for the rectangle-fill byte sequencer.
package dfrs_pkg;

    typedef logic [7:0]  t_coord;
    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_chan;
    typedef logic [3:0]  t_step;
    typedef logic [1:0]  t_phase;
    typedef logic [15:0] t_pairs;
    typedef logic [11:0] t_colour;

    // Request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_SLOT  = 1'b1;

    // Display command bytes and filler
    localparam t_byte CMD_COL_SET   = 8'h2A;
    localparam t_byte CMD_ROW_SET   = 8'h2B;
    localparam t_byte CMD_MEM_WRITE = 8'h2C;
    localparam t_byte BYTE_ZERO     = 8'h00;

    // Header step codes; unlisted steps send a zero data byte
    localparam t_step STEP_COL_CMD   = 4'd0;
    localparam t_step STEP_COL_FIRST = 4'd2;
    localparam t_step STEP_COL_FINAL = 4'd4;
    localparam t_step STEP_ROW_CMD   = 4'd5;
    localparam t_step STEP_ROW_FIRST = 4'd7;
    localparam t_step STEP_ROW_FINAL = 4'd9;
    localparam t_step STEP_MEM_CMD   = 4'd10;
    localparam t_step STEP_PIXEL     = 4'd11;

    // Triplet phases: {R,G}, {B,R}, {G,B}
    localparam t_phase PHASE_RG = 2'd0;
    localparam t_phase PHASE_BR = 2'd1;
    localparam t_phase PHASE_GB = 2'd2;

    // One input request
    typedef struct packed {
        logic   opcode;
        t_coord col_start;
        t_coord row_start;
        t_coord width_span;
        t_coord height_span;
        t_chan  red;
        t_chan  green;
        t_chan  blue;
    } t_req;

endpackage

@@ src/display_fill_rect_byte_sequencer.sv @@
// Top level of the rectangle-fill display byte sequencer.
// A slot request passes the input register and then the output register before its byte is on the output.
// Throughput: one request per cycle when the output is not stalled; start requests and idle slots give no byte.
// The input register and the output register decouple the two sides under stall.
// Reset (synchronous, active low) clears both stages and leaves the sequencer idle.
module display_fill_rect_byte_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_opcode,
    input  dfrs_pkg::t_coord i_col_start,
    input  dfrs_pkg::t_coord i_row_start,
    input  dfrs_pkg::t_coord i_width_span,
    input  dfrs_pkg::t_coord i_height_span,
    input  dfrs_pkg::t_chan  i_red,
    input  dfrs_pkg::t_chan  i_green,
    input  dfrs_pkg::t_chan  i_blue,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dfrs_pkg::t_byte  o_out_byte,
    output logic            o_is_data,
    output logic            o_final_byte
);
    import dfrs_pkg::*;

    t_req in_req;
    t_req stage_req;
    logic stage_valid;
    logic stage_take;

    // Gather the request fields
    always_comb begin
        in_req.opcode      = i_opcode;
        in_req.col_start   = i_col_start;
        in_req.row_start   = i_row_start;
        in_req.width_span  = i_width_span;
        in_req.height_span = i_height_span;
        in_req.red         = i_red;
        in_req.green       = i_green;
        in_req.blue        = i_blue;
    end

    dfrs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (in_req),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_req   (stage_req)
    );

    dfrs_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (stage_valid),
        .i_req        (stage_req),
        .o_take       (stage_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_final_byte (o_final_byte)
    );

endmodule

@@ src/dfrs_in_stage.sv @@
// Input register stage: holds one request until the engine takes it.
module dfrs_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dfrs_pkg::t_req i_req,
    input  logic          i_take,
    output logic          o_valid,
    output dfrs_pkg::t_req o_req
);
    import dfrs_pkg::*;

    logic r_valid;
    t_req r_req;

    // Full and not drained this cycle: hold off the sender
    assign o_stall = r_valid && !i_take;

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload, loaded on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

@@ src/dfrs_engine.sv @@
// Sequencer state, byte generation and output register.
module dfrs_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  dfrs_pkg::t_req i_req,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dfrs_pkg::t_byte o_out_byte,
    output logic           o_is_data,
    output logic           o_final_byte
);
    import dfrs_pkg::*;
    `include "display_fill_rect_byte_sequencer_assert.svh"

    logic    r_busy, n_busy;
    t_step   r_header_step, n_header_step;
    t_pairs  r_pairs_left, n_pairs_left;
    t_phase  r_triplet_phase, n_triplet_phase;
    t_coord  r_col_first, n_col_first;
    t_coord  r_col_final, n_col_final;
    t_coord  r_row_first, n_row_first;
    t_coord  r_row_final, n_row_final;
    t_colour r_fill_colour, n_fill_colour;

    logic    r_out_valid;
    t_byte   r_out_byte;
    logic    r_out_data;
    logic    r_out_final;

    logic    out_free;
    logic    res_valid;
    t_byte   res_byte;
    logic    res_data;
    logic    res_final;
    logic [8:0]  w_ext, h_ext;
    logic [17:0] area;
    t_coord  col_one, row_one;
    t_chan   fc_r, fc_g, fc_b;

    // Output slot free, so the pending request can be consumed
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_take   = i_req_valid && out_free;

    // Start-request arithmetic: offsets, wrapped ends, triplet count
    assign w_ext   = {1'b0, i_req.width_span} + 9'd1;
    assign h_ext   = {1'b0, i_req.height_span} + 9'd1;
    assign area    = w_ext * h_ext;
    assign col_one = i_req.col_start + 8'd1;
    assign row_one = i_req.row_start + 8'd1;

    assign fc_r = r_fill_colour[11:8];
    assign fc_g = r_fill_colour[7:4];
    assign fc_b = r_fill_colour[3:0];

    // Next state and result for the request being consumed
    always_comb begin
        n_busy          = r_busy;
        n_header_step   = r_header_step;
        n_pairs_left    = r_pairs_left;
        n_triplet_phase = r_triplet_phase;
        n_col_first     = r_col_first;
        n_col_final     = r_col_final;
        n_row_first     = r_row_first;
        n_row_final     = r_row_final;
        n_fill_colour   = r_fill_colour;
        res_valid       = 1'b0;
        res_byte        = BYTE_ZERO;
        res_data        = 1'b1;
        res_final       = 1'b0;
        if (o_take) begin
            if (i_req.opcode == OP_START) begin
                n_col_first     = col_one;
                n_col_final     = col_one + i_req.width_span;
                n_row_first     = row_one;
                n_row_final     = row_one + i_req.height_span;
                n_fill_colour   = {i_req.red, i_req.green, i_req.blue};
                n_pairs_left    = area[16:1];
                n_header_step   = STEP_COL_CMD;
                n_triplet_phase = PHASE_RG;
                n_busy          = 1'b1;
            end else if (r_busy) begin
                if (r_header_step < STEP_PIXEL) begin
                    // Address window and memory-write header
                    res_valid = 1'b1;
                    case (r_header_step)
                        STEP_COL_CMD: begin
                            res_byte = CMD_COL_SET;
                            res_data = 1'b0;
                        end
                        STEP_COL_FIRST: res_byte = r_col_first;
                        STEP_COL_FINAL: res_byte = r_col_final;
                        STEP_ROW_CMD: begin
                            res_byte = CMD_ROW_SET;
                            res_data = 1'b0;
                        end
                        STEP_ROW_FIRST: res_byte = r_row_first;
                        STEP_ROW_FINAL: res_byte = r_row_final;
                        STEP_MEM_CMD: begin
                            res_byte = CMD_MEM_WRITE;
                            res_data = 1'b0;
                        end
                        default: res_byte = BYTE_ZERO;
                    endcase
                    n_header_step = r_header_step + 4'd1;
                    if (r_header_step == STEP_MEM_CMD && r_pairs_left == '0) begin
                        res_final = 1'b1;
                        n_busy    = 1'b0;
                    end
                end else if (r_pairs_left == '0) begin
                    n_busy = 1'b0;
                end else begin
                    // Pixel triplets, two pixels per three bytes
                    res_valid = 1'b1;
                    case (r_triplet_phase)
                        PHASE_RG: begin
                            res_byte        = {fc_r, fc_g};
                            n_triplet_phase = PHASE_BR;
                        end
                        PHASE_BR: begin
                            res_byte        = {fc_b, fc_r};
                            n_triplet_phase = PHASE_GB;
                        end
                        default: begin
                            res_byte        = {fc_g, fc_b};
                            n_triplet_phase = PHASE_RG;
                            n_pairs_left    = r_pairs_left - 16'd1;
                            if (r_pairs_left == 16'd1) begin
                                res_final = 1'b1;
                                n_busy    = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_header_step   <= STEP_COL_CMD;
            r_pairs_left    <= '0;
            r_triplet_phase <= PHASE_RG;
        end else begin
            r_busy          <= n_busy;
            r_header_step   <= n_header_step;
            r_pairs_left    <= n_pairs_left;
            r_triplet_phase <= n_triplet_phase;
        end
    end

    // Rectangle and colour, written only by a start request
    always_ff @(posedge i_clk) begin
        r_col_first   <= n_col_first;
        r_col_final   <= n_col_final;
        r_row_first   <= n_row_first;
        r_row_final   <= n_row_final;
        r_fill_colour <= n_fill_colour;
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_take && res_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_take && res_valid) begin
            r_out_byte  <= res_byte;
            r_out_data  <= res_data;
            r_out_final <= res_final;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_data    = r_out_data;
    assign o_final_byte = r_out_final;

    // Checks
    `DFRS_ASSERT_ALWAYS(a_step_range, i_clk, i_rst_n, r_header_step <= STEP_PIXEL, "header step past pixel body")
    `DFRS_ASSERT_ALWAYS(a_phase_range, i_clk, i_rst_n, r_triplet_phase <= PHASE_GB, "bad triplet phase")
    `DFRS_ASSERT_ALWAYS(a_pixel_pairs, i_clk, i_rst_n, !(r_busy && r_header_step == STEP_PIXEL && r_pairs_left == '0), "busy in pixel body with no triplets left")
    `DFRS_ASSERT_NEXT(a_final_idle, i_clk, i_rst_n, o_take && res_valid && res_final, !r_busy && r_out_valid && r_out_final, "final byte did not end the run")

endmodule

@@ sim/tb_display_fill_rect_byte_sequencer.sv @@
// Self-checking testbench for the rectangle-fill display byte sequencer.
module tb_display_fill_rect_byte_sequencer;
    import dfrs_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned CYCLE_LIMIT  = 600_000;
    localparam int unsigned DRAIN_TAIL   = 8;
    localparam int unsigned MAX_REPORTS  = 100;

    // One byte on the display link
    typedef struct packed {
        t_byte value;
        logic  is_data;
        logic  last;
    } disp_byte_t;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    logic    i_opcode = OP_SLOT;
    t_coord  i_col_start = '0;
    t_coord  i_row_start = '0;
    t_coord  i_width_span = '0;
    t_coord  i_height_span = '0;
    t_chan   i_red = '0;
    t_chan   i_green = '0;
    t_chan   i_blue = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_byte   o_out_byte;
    logic    o_is_data;
    logic    o_final_byte;

    // Predictor state
    logic    fill_busy = 1'b0;
    t_step   hdr_step = '0;
    t_pairs  pairs_left = '0;
    t_phase  trip_phase = PHASE_RG;
    t_coord  col_first = '0;
    t_coord  col_final = '0;
    t_coord  row_first = '0;
    t_coord  row_final = '0;
    t_colour fill_colour = '0;

    disp_byte_t  pending_bytes[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    // Pacing knobs
    bit          idle_en = 1'b1;
    int unsigned gap_max = 4;
    int unsigned burst_left = 0;
    int unsigned stall_pct = 30;
    int unsigned stall_run = 0;
    logic        stall_now = 1'b0;

    display_fill_rect_byte_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_col_start   (i_col_start),
        .i_row_start   (i_row_start),
        .i_width_span  (i_width_span),
        .i_height_span (i_height_span),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_is_data     (o_is_data),
        .o_final_byte  (o_final_byte)
    );

    always #5 i_clk = ~i_clk;

    // Receiver stall: runs of stall or flow, mostly short, now and then long
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_now = ($urandom_range(99) < stall_pct);
            stall_run = ($urandom_range(15) == 0) ? $urandom_range(40, 1)
                                                  : $urandom_range(4, 1);
        end
        stall_run = stall_run - 1;
        i_out_stall <= stall_now;
    end

    // Expected display bytes for one accepted request
    function automatic void predict_display_bytes(t_req rq);
        disp_byte_t  rec;
        int unsigned pairs;
        t_coord      x1;
        t_coord      y1;
        if (rq.opcode == OP_START) begin
            x1 = rq.col_start + 8'd1;
            y1 = rq.row_start + 8'd1;
            col_first   = x1;
            col_final   = x1 + rq.width_span;
            row_first   = y1;
            row_final   = y1 + rq.height_span;
            fill_colour = {rq.red, rq.green, rq.blue};
            pairs = ((int'(rq.width_span) + 1) * (int'(rq.height_span) + 1)) / 2;
            pairs_left = (pairs > 32'hFFFF) ? 16'hFFFF : t_pairs'(pairs);
            hdr_step   = STEP_COL_CMD;
            trip_phase = PHASE_RG;
            fill_busy  = 1'b1;
        end else if (fill_busy) begin
            rec.is_data = 1'b1;
            rec.last    = 1'b0;
            if (hdr_step < STEP_PIXEL) begin
                case (hdr_step)
                    STEP_COL_CMD: begin
                        rec.value   = CMD_COL_SET;
                        rec.is_data = 1'b0;
                    end
                    STEP_COL_FIRST: rec.value = col_first;
                    STEP_COL_FINAL: rec.value = col_final;
                    STEP_ROW_CMD: begin
                        rec.value   = CMD_ROW_SET;
                        rec.is_data = 1'b0;
                    end
                    STEP_ROW_FIRST: rec.value = row_first;
                    STEP_ROW_FINAL: rec.value = row_final;
                    STEP_MEM_CMD: begin
                        rec.value   = CMD_MEM_WRITE;
                        rec.is_data = 1'b0;
                    end
                    default: rec.value = BYTE_ZERO;
                endcase
                hdr_step = hdr_step + 4'd1;
                // empty pixel body: memory write closes the sequence
                if (hdr_step == STEP_PIXEL && pairs_left == 0) begin
                    rec.last  = 1'b1;
                    fill_busy = 1'b0;
                end
                pending_bytes.push_back(rec);
            end else if (pairs_left == 0) begin
                fill_busy = 1'b0;
            end else begin
                case (trip_phase)
                    PHASE_RG: begin
                        rec.value  = {fill_colour[11:8], fill_colour[7:4]};
                        trip_phase = PHASE_BR;
                    end
                    PHASE_BR: begin
                        rec.value  = {fill_colour[3:0], fill_colour[11:8]};
                        trip_phase = PHASE_GB;
                    end
                    default: begin
                        rec.value  = {fill_colour[7:4], fill_colour[3:0]};
                        trip_phase = PHASE_RG;
                        pairs_left = pairs_left - 16'd1;
                        if (pairs_left == 0) begin
                            rec.last  = 1'b1;
                            fill_busy = 1'b0;
                        end
                    end
                endcase
                pending_bytes.push_back(rec);
            end
        end
    endfunction

    function automatic void report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        // cap the log on a badly broken build
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected %02h, actual %02h", $time, what, want, got);
    endfunction

    // Compare every accepted byte with the oldest expectation
    always @(posedge i_clk) begin : check_bytes
        disp_byte_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t unexpected byte: expected none, actual %02h dc=%0b last=%0b",
                             $time, o_out_byte, o_is_data, o_final_byte);
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.value)
                    report_mismatch("out_byte", want.value, o_out_byte);
                if (o_is_data !== want.is_data)
                    report_mismatch("is_data", {7'd0, want.is_data}, {7'd0, o_is_data});
                if (o_final_byte !== want.last)
                    report_mismatch("final_byte", {7'd0, want.last}, {7'd0, o_final_byte});
            end
        end
    end

    // Run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_req start_req(t_coord x, t_coord y, t_coord w, t_coord h,
                                       t_chan r, t_chan g, t_chan b);
        t_req rq;
        rq.opcode      = OP_START;
        rq.col_start   = x;
        rq.row_start   = y;
        rq.width_span  = w;
        rq.height_span = h;
        rq.red         = r;
        rq.green       = g;
        rq.blue        = b;
        return rq;
    endfunction

    // Slot request; the other fields carry random junk the block must ignore
    function automatic t_req slot_req();
        logic [63:0] junk;
        t_req        rq;
        junk = {$urandom(), $urandom()};
        rq = t_req'(junk[$bits(t_req)-1:0]);
        rq.opcode = OP_SLOT;
        return rq;
    endfunction

    // Send one request and hold it until accepted; valid stays high in a burst
    task automatic send_req(t_req rq);
        i_in_valid    <= 1'b1;
        i_opcode      <= rq.opcode;
        i_col_start   <= rq.col_start;
        i_row_start   <= rq.row_start;
        i_width_span  <= rq.width_span;
        i_height_span <= rq.height_span;
        i_red         <= rq.red;
        i_green       <= rq.green;
        i_blue        <= rq.blue;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (rq.opcode == OP_START || fill_busy) items_sent++;
        predict_display_bytes(rq);
        // end of burst: drop valid for a random gap
        if (idle_en) begin
            if (burst_left <= 1) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
                burst_left = $urandom_range(16, 1);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Hold off until every expected byte has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic set_pacing(bit idle, int unsigned gap, int unsigned pct);
        idle_en   = idle;
        gap_max   = gap;
        stall_pct = pct;
    endtask

    // Start a fill, then request bytes until the last one or until cut slots
    task automatic run_fill(t_req start, int unsigned cut);
        int unsigned n;
        n = 0;
        send_req(start);
        while (fill_busy && (cut == 0 || n < cut)) begin
            send_req(slot_req());
            n++;
        end
    endtask

    task automatic test_idle_slot();
        send_req(slot_req());
    endtask

    // Full-size rectangle, dropped a couple of bytes into the pixel body
    task automatic test_restart_mid_run();
        run_fill(start_req(8'd0, 8'd255, 8'd255, 8'd255, 4'hA, 4'h5, 4'hF), 13);
    endtask

    // Restart onto a one-pixel rectangle at the wrap edge: memory write is last
    task automatic test_empty_body_wrap();
        run_fill(start_req(8'd255, 8'd254, 8'd0, 8'd0, 4'hF, 4'h0, 4'hF), 0);
        send_req(slot_req());
    endtask

    // One wide and one tall strip at the maximum span
    task automatic test_long_strips();
        set_pacing(1'b0, 1, 0);
        run_fill(start_req(t_coord'($urandom_range(255)), t_coord'($urandom_range(255)),
                           8'd255, 8'd0,
                           t_chan'($urandom_range(15)), t_chan'($urandom_range(15)),
                           t_chan'($urandom_range(15))), 0);
        wait_drained();
        set_pacing(1'b1, 8, 85);
        run_fill(start_req(t_coord'($urandom_range(255)), t_coord'($urandom_range(255)),
                           8'd0, 8'd255,
                           t_chan'($urandom_range(15)), t_chan'($urandom_range(15)),
                           t_chan'($urandom_range(15))), 0);
    endtask

    // Mostly complete small fills; some cut short, some wide or tall strips, idle slots as noise
    task automatic test_random_fills();
        int unsigned base;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned pairs;
        int unsigned cut;
        int unsigned pct;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: pct = 0;
                    1: pct = 15;
                    2: pct = 50;
                    default: pct = 85;
                endcase
                set_pacing($urandom_range(1) == 1, $urandom_range(12, 1), pct);
            end
            sel = $urandom_range(99);
            if (sel < 8 && !fill_busy) begin
                repeat ($urandom_range(3, 1)) send_req(slot_req());
            end else begin
                if (sel < 11) begin
                    w = $urandom_range(255);
                    h = 0;
                end else if (sel < 14) begin
                    w = 0;
                    h = $urandom_range(255);
                end else begin
                    w = $urandom_range(7);
                    h = $urandom_range(7);
                end
                pairs = ((w + 1) * (h + 1)) / 2;
                cut = ($urandom_range(6) == 0) ? $urandom_range(10 + 3 * pairs, 1) : 0;
                run_fill(start_req(t_coord'($urandom_range(255)),
                                   t_coord'($urandom_range(255)),
                                   t_coord'(w), t_coord'(h),
                                   t_chan'($urandom_range(15)), t_chan'($urandom_range(15)),
                                   t_chan'($urandom_range(15))), cut);
                if ($urandom_range(19) == 0) wait_drained();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_slot();
        test_restart_mid_run();
        test_empty_body_wrap();
        wait_drained();
        test_long_strips();
        wait_drained();
        set_pacing(1'b1, 4, 30);
        test_random_fills();
        wait_drained();
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
